// ----- rtl/ipd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed postbyte decoder package
// Shared types, mode codes and the nibble-to-kind table of the decoder.
// ----------------------------------------------------------------------------
package ipd_pkg;

   // Dense mode kinds reported on the result channel.
   localparam logic [3:0] KIND_FIVE_BIT    = 4'd0;
   localparam logic [3:0] KIND_POST_INC1   = 4'd1;
   localparam logic [3:0] KIND_POST_INC2   = 4'd2;
   localparam logic [3:0] KIND_PRE_DEC1    = 4'd3;
   localparam logic [3:0] KIND_PRE_DEC2    = 4'd4;
   localparam logic [3:0] KIND_NO_OFFSET   = 4'd5;
   localparam logic [3:0] KIND_ACC_B       = 4'd6;
   localparam logic [3:0] KIND_ACC_A       = 4'd7;
   localparam logic [3:0] KIND_OFF8        = 4'd8;
   localparam logic [3:0] KIND_OFF16       = 4'd9;
   localparam logic [3:0] KIND_ACC_D       = 4'd10;
   localparam logic [3:0] KIND_PC8         = 4'd11;
   localparam logic [3:0] KIND_PC16        = 4'd12;
   localparam logic [3:0] KIND_EXT_IND     = 4'd13;
   localparam logic [3:0] KIND_ILLEGAL     = 4'd14;

   // Low-nibble codes of the postbyte when bit 7 is set.
   localparam logic [3:0] NIB_POST_INC1    = 4'h0;
   localparam logic [3:0] NIB_POST_INC2    = 4'h1;
   localparam logic [3:0] NIB_PRE_DEC1     = 4'h2;
   localparam logic [3:0] NIB_PRE_DEC2     = 4'h3;
   localparam logic [3:0] NIB_NO_OFFSET    = 4'h4;
   localparam logic [3:0] NIB_ACC_B        = 4'h5;
   localparam logic [3:0] NIB_ACC_A        = 4'h6;
   localparam logic [3:0] NIB_UNUSED_7     = 4'h7;
   localparam logic [3:0] NIB_OFF8         = 4'h8;
   localparam logic [3:0] NIB_OFF16        = 4'h9;
   localparam logic [3:0] NIB_UNUSED_A     = 4'hA;
   localparam logic [3:0] NIB_ACC_D        = 4'hB;
   localparam logic [3:0] NIB_PC8          = 4'hC;
   localparam logic [3:0] NIB_PC16         = 4'hD;
   localparam logic [3:0] NIB_UNUSED_E     = 4'hE;
   localparam logic [3:0] NIB_EXT_IND      = 4'hF;

   // Base register code of the system stack pointer.
   localparam logic [1:0] BASE_S           = 2'd3;

   // Largest magnitude accepted for a 16-bit PC-relative offset.
   localparam logic signed [15:0] PC_OFF_LIMIT = 16'sd32000;

   // One input beat.
   typedef struct packed {
      logic [7:0]  postbyte;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [1:0]  bytes_available;
      logic [15:0] pc;
      logic [1:0]  opcode_bytes;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic               valid_res;
      logic               indirect;
      logic [1:0]         extra_bytes;
      logic [1:0]         base_register;
      logic [3:0]         mode_kind;
      logic signed [15:0] offset;
      logic [15:0]        target_addr;
   } rsp_type;

   // Mode kind of a postbyte with bit 7 set, by its low nibble.
   function automatic logic [3:0] kind_of_nibble(input logic [3:0] nib);
      logic [3:0] kind;
      unique case (nib)
         NIB_POST_INC1: kind = KIND_POST_INC1;
         NIB_POST_INC2: kind = KIND_POST_INC2;
         NIB_PRE_DEC1:  kind = KIND_PRE_DEC1;
         NIB_PRE_DEC2:  kind = KIND_PRE_DEC2;
         NIB_NO_OFFSET: kind = KIND_NO_OFFSET;
         NIB_ACC_B:     kind = KIND_ACC_B;
         NIB_ACC_A:     kind = KIND_ACC_A;
         NIB_OFF8:      kind = KIND_OFF8;
         NIB_OFF16:     kind = KIND_OFF16;
         NIB_ACC_D:     kind = KIND_ACC_D;
         NIB_PC8:       kind = KIND_PC8;
         NIB_PC16:      kind = KIND_PC16;
         NIB_EXT_IND:   kind = KIND_EXT_IND;
         default:       kind = KIND_ILLEGAL;
      endcase
      return kind;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/ipd_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed postbyte decode logic
// Combinational decode of one registered input beat into one result beat,
// including the PC-relative target adder and its range checks.
// ----------------------------------------------------------------------------
module ipd_decode (
   input  ipd_pkg::req_type req,
   output ipd_pkg::rsp_type rsp
);

   logic [3:0]         nib;
   logic               ibit;
   logic [1:0]         base;
   logic               have2;
   logic               have3;
   logic signed [15:0] off8;
   logic signed [15:0] off16;
   logic signed [15:0] pc_off;
   logic [16:0]        pc_next;
   logic [17:0]        pc_sum;
   logic               pc_in_range;
   logic               off16_in_limit;

   assign nib   = req.postbyte[3:0];
   assign ibit  = req.postbyte[4];
   assign base  = req.postbyte[6:5];
   assign have2 = req.bytes_available[1];
   assign have3 = (req.bytes_available == 2'd3);

   // Sign-extended constant offsets from the following bytes.
   assign off8  = {{8{req.byte1[7]}}, req.byte1};
   assign off16 = {req.byte1, req.byte2};

   // PC-relative target: address after the whole instruction plus offset.
   // One adder serves both the 8-bit and the 16-bit form.
   assign pc_off  = (nib == ipd_pkg::NIB_PC16) ? off16 : off8;
   assign pc_next = {1'b0, req.pc} + {15'd0, req.opcode_bytes}
                    + ((nib == ipd_pkg::NIB_PC16) ? 17'd3 : 17'd2);
   assign pc_sum  = {1'b0, pc_next} + {{2{pc_off[15]}}, pc_off};
   // The sum is a signed 18-bit value; it fits the address space only when
   // its two top bits are clear.
   assign pc_in_range    = (pc_sum[17:16] == 2'b00);
   assign off16_in_limit = (off16 <= ipd_pkg::PC_OFF_LIMIT)
                           && (off16 >= -ipd_pkg::PC_OFF_LIMIT);

   // Main decode of the postbyte.
   always_comb begin
      rsp.valid_res      = 1'b0;
      rsp.indirect       = 1'b0;
      rsp.extra_bytes    = 2'd0;
      rsp.base_register  = 2'd0;
      rsp.mode_kind      = ipd_pkg::KIND_ILLEGAL;
      rsp.offset         = 16'sd0;
      rsp.target_addr    = 16'd0;
      if (req.bytes_available != 2'd0) begin
         rsp.base_register = base;
         rsp.valid_res     = 1'b1;
         if (!req.postbyte[7]) begin
            // Five-bit signed offset held in the postbyte itself.
            rsp.mode_kind = ipd_pkg::KIND_FIVE_BIT;
            rsp.offset    = {{11{req.postbyte[4]}}, req.postbyte[4:0]};
         end else if (ibit && (base == ipd_pkg::BASE_S) && (nib != ipd_pkg::NIB_EXT_IND)) begin
            // Indirect through the stack pointer is refused.
            rsp.valid_res = 1'b0;
         end else begin
            rsp.mode_kind = ipd_pkg::kind_of_nibble(nib);
            rsp.indirect  = ibit || (nib == ipd_pkg::NIB_EXT_IND);
            unique case (nib) inside
               ipd_pkg::NIB_OFF8: begin
                  if (have2) begin
                     rsp.offset      = off8;
                     rsp.extra_bytes = 2'd1;
                  end else begin
                     rsp.valid_res = 1'b0;
                  end
               end
               ipd_pkg::NIB_OFF16: begin
                  if (have3) begin
                     rsp.offset      = off16;
                     rsp.extra_bytes = 2'd2;
                  end else begin
                     rsp.valid_res = 1'b0;
                  end
               end
               ipd_pkg::NIB_PC8: begin
                  if (have2) begin
                     rsp.offset      = off8;
                     rsp.extra_bytes = 2'd1;
                     if (pc_in_range) begin
                        rsp.target_addr = pc_sum[15:0];
                     end else begin
                        rsp.valid_res = 1'b0;
                     end
                  end else begin
                     rsp.valid_res = 1'b0;
                  end
               end
               ipd_pkg::NIB_PC16: begin
                  if (have3) begin
                     rsp.offset      = off16;
                     rsp.extra_bytes = 2'd2;
                     if (pc_in_range && off16_in_limit) begin
                        rsp.target_addr = pc_sum[15:0];
                     end else begin
                        rsp.valid_res = 1'b0;
                     end
                  end else begin
                     rsp.valid_res = 1'b0;
                  end
               end
               ipd_pkg::NIB_EXT_IND: begin
                  if (ibit && have3) begin
                     rsp.target_addr = {req.byte1, req.byte2};
                     rsp.extra_bytes = 2'd2;
                  end else begin
                     rsp.valid_res = 1'b0;
                  end
               end
               ipd_pkg::NIB_UNUSED_7, ipd_pkg::NIB_UNUSED_A, ipd_pkg::NIB_UNUSED_E: begin
                  rsp.valid_res = 1'b0;
               end
               default: begin
                  // Register-only forms need no further bytes.
                  rsp.valid_res = 1'b1;
               end
            endcase
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/indexed_postbyte_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed postbyte decoder
// Decodes an indexed-addressing postbyte and its following bytes into base
// register, mode kind, offset, operand length, indirect flag and target.
// ----------------------------------------------------------------------------
// A beat is taken whenever start is high; busy never rises. Each beat gives
// exactly one result after the input and result registers, shown for one
// cycle with rsp_strobe high. Beats may be issued on every cycle: the input
// register, the decode logic with its single target adder, and the result
// register form a two-stage pipeline that carries one beat per cycle.
module indexed_postbyte_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [7:0]         req_postbyte,
   input  wire logic [7:0]         req_byte1,
   input  wire logic [7:0]         req_byte2,
   input  wire logic [1:0]         req_bytes_available,
   input  wire logic [15:0]        req_pc,
   input  wire logic [1:0]         req_opcode_bytes,
   output      logic               rsp_strobe,
   output      logic               rsp_valid_res,
   output      logic               rsp_indirect,
   output      logic [1:0]         rsp_extra_bytes,
   output      logic [1:0]         rsp_base_register,
   output      logic [3:0]         rsp_mode_kind,
   output      logic signed [15:0] rsp_offset,
   output      logic [15:0]        rsp_target_addr
);

   ipd_pkg::req_type req_in;
   ipd_pkg::req_type req_ff;
   logic             req_valid_ff;
   ipd_pkg::rsp_type rsp_in;
   ipd_pkg::rsp_type rsp_ff;
   logic             rsp_strobe_ff;

   // The pipeline never stalls.
   assign busy = 1'b0;

   // Gather the input beat.
   assign req_in.postbyte        = req_postbyte;
   assign req_in.byte1           = req_byte1;
   assign req_in.byte2           = req_byte2;
   assign req_in.bytes_available = req_bytes_available;
   assign req_in.pc              = req_pc;
   assign req_in.opcode_bytes    = req_opcode_bytes;

   // Input register stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
      if (start) begin
         req_ff <= req_in;
      end
   end

   // Decode logic between the two register stages.
   ipd_decode u_decode (
      .req (req_ff),
      .rsp (rsp_in)
   );

   // Result register stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   // Result ports.
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_valid_res      = rsp_ff.valid_res;
   assign rsp_indirect       = rsp_ff.indirect;
   assign rsp_extra_bytes    = rsp_ff.extra_bytes;
   assign rsp_base_register  = rsp_ff.base_register;
   assign rsp_mode_kind      = rsp_ff.mode_kind;
   assign rsp_offset         = rsp_ff.offset;
   assign rsp_target_addr    = rsp_ff.target_addr;

   // Every beat in the input register produces a result on the next cycle.
   a_beat_reaches_result: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_strobe)
      else $error("decoded beat did not reach the result register");

   // A refused form never carries a target address.
   a_invalid_no_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_res) |-> (rsp_target_addr == 16'd0))
      else $error("invalid result carries a target address");

   // An accepted form always has a real mode kind.
   a_valid_has_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_valid_res) |-> (rsp_mode_kind != ipd_pkg::KIND_ILLEGAL))
      else $error("valid result reports the illegal mode kind");

   // At most two operand bytes follow the postbyte.
   a_extra_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_extra_bytes != 2'd3))
      else $error("result claims three extra bytes");

endmodule
`default_nettype wire
